// ===== hw/rtl/lpp_pkg.sv =====
package lpp_pkg;

   // sizes
   localparam int PATTERN_DEPTH = 64;
   localparam int FOREVER_COUNT = 255;
   localparam int ADDR_W        = $clog2(PATTERN_DEPTH);

   localparam int ACTION_W  = 2;
   localparam int ENTRY_W   = 6;
   localparam int COLOR_W   = 8;
   localparam int SEQ_NUM_W = 4;
   localparam int START_W   = 6;
   localparam int LENGTH_W  = 7;
   localparam int POS_W     = 6;
   localparam int COUNT_W   = 8;
   localparam int MODE_W    = 2;
   localparam int WORD_W    = 3 * COLOR_W;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;

   // dimming curve
   localparam int DIM_THRESHOLD = 9;
   localparam int DIM_OFFSET    = 7;
   localparam int DIM_BASE      = 8;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SELECT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd2;

   // sleep modes
   localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DIM    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_OFF    = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SEQUENCE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLEEP_MODE   = 1'd1;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } lpp_state_type;

   typedef struct packed {
      logic [ACTION_W-1:0]  action;
      logic [ENTRY_W-1:0]   entry_addr;
      logic [COLOR_W-1:0]   red_in;
      logic [COLOR_W-1:0]   green_in;
      logic [COLOR_W-1:0]   blue_in;
      logic [SEQ_NUM_W-1:0] seq_number;
      logic [START_W-1:0]   seq_start;
      logic [LENGTH_W-1:0]  seq_length;
      logic [COUNT_W-1:0]   repeat_count;
   } lpp_req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red_out;
      logic [COLOR_W-1:0] green_out;
      logic [COLOR_W-1:0] blue_out;
      logic               turned_off;
   } lpp_rsp_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } lpp_csr_type;

endpackage

// ===== hw/rtl/lpp_if.sv =====
interface lpp_req_if;
   import lpp_pkg::*;
   logic        valid;
   logic        ready;
   lpp_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lpp_rsp_if;
   import lpp_pkg::*;
   logic        valid;
   logic        ready;
   lpp_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lpp_csr_if;
   import lpp_pkg::*;
   logic        valid;
   logic        ready;
   lpp_csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/lpp_ram.sv =====
module lpp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/led_pattern_player.sv =====
// led pattern player: plays rgb colour sequences out of a 64-entry pattern memory, one colour
// per tick transaction. a load transaction writes one colour, a select transaction starts a
// sequence (start, length, repeat count; 255 repeats forever, number 0 turns the led off on the
// next tick, reselecting the same nonzero number keeps the position). when the passes run out
// the next tick gives one off transaction with turned_off set and the player goes idle. loads,
// selects and ticks that give no result are taken in the idle state; a tick that gives a result
// moves to the read state for the registered read of the pattern memory and stays there while
// an earlier result still sits in the output register. register 0 sets the highest accepted
// sequence number, register 1 the sleep mode (0 normal, 1 dim, 2 ticks ignored).
module led_pattern_player (
   input  logic      clock,
   input  logic      reset,
   lpp_req_if.sink   req_chan,
   lpp_rsp_if.source rsp_chan,
   lpp_csr_if.sink   csr_chan
);

   import lpp_pkg::*;

   // dimming: c >= 9 maps to (c - 7) / 2 + 8
   function automatic logic [COLOR_W-1:0] dim_color(input logic [COLOR_W-1:0] c);
      logic [COLOR_W-1:0] half;
      half = (c - COLOR_W'(DIM_OFFSET)) >> 1;
      if (c >= COLOR_W'(DIM_THRESHOLD)) begin
         return half + COLOR_W'(DIM_BASE);
      end
      return c;
   endfunction

   // control state
   lpp_state_type        state_ff, state_in;
   logic [SEQ_NUM_W-1:0] max_seq_ff;
   logic [MODE_W-1:0]    sleep_mode_ff;
   logic [START_W-1:0]   start_ff, start_in;
   logic [LENGTH_W-1:0]  length_ff, length_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [COUNT_W-1:0]   passes_ff, passes_in;
   logic [SEQ_NUM_W-1:0] prev_num_ff, prev_num_in;
   logic                 pend_off_ff, pend_off_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // output payload register
   lpp_rsp_type rsp_ff, rsp_in;

   // pattern memory port
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;

   logic               req_accept;
   logic               rsp_free;
   logic [START_W:0]   addr_sum;
   logic [LENGTH_W-1:0] next_pos;
   lpp_req_type        req;

   assign req               = req_chan.payload;
   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign req_accept        = req_chan.valid && req_chan.ready;
   assign rsp_free          = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.payload  = rsp_ff;
   assign csr_chan.ready    = 1'b1;

   // memory addressing, wraps modulo the depth
   assign addr_sum = {1'b0, start_ff} + {1'b0, pos_ff};
   assign rd_addr  = ADDR_W'(addr_sum % PATTERN_DEPTH);
   assign wr_addr  = ADDR_W'(req.entry_addr % PATTERN_DEPTH);
   assign wr_data  = {req.red_in, req.green_in, req.blue_in};
   assign next_pos = {1'b0, pos_ff} + LENGTH_W'(1);

   lpp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (PATTERN_DEPTH)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_seq_ff    <= SEQ_NUM_W'(15);
         sleep_mode_ff <= MODE_NORMAL;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.payload.index)
            CSR_MAX_SEQUENCE: max_seq_ff    <= csr_chan.payload.data[SEQ_NUM_W-1:0];
            CSR_SLEEP_MODE:   sleep_mode_ff <= csr_chan.payload.data[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         length_ff    <= '0;
         pos_ff       <= '0;
         passes_ff    <= '0;
         prev_num_ff  <= '0;
         pend_off_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         length_ff    <= length_in;
         pos_ff       <= pos_in;
         passes_ff    <= passes_in;
         prev_num_ff  <= prev_num_in;
         pend_off_ff  <= pend_off_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // sequencing: state updates at acceptance, the result lands after the memory read
   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      length_in    = length_ff;
      pos_in       = pos_ff;
      passes_in    = passes_ff;
      prev_num_in  = prev_num_ff;
      pend_off_in  = pend_off_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req.action)
                  ACT_LOAD: begin
                     wr_en = 1'b1;
                  end
                  ACT_SELECT: begin
                     if (req.seq_number <= max_seq_ff) begin
                        if (req.seq_number == '0) begin
                           // black: one off transaction on the next tick
                           length_in = LENGTH_W'(1);
                           passes_in = '0;
                           pos_in    = '0;
                        end else begin
                           start_in  = req.seq_start;
                           length_in = req.seq_length;
                           passes_in = req.repeat_count;
                        end
                        if (req.seq_number != prev_num_ff) begin
                           pos_in = '0;
                        end
                        prev_num_in = req.seq_number;
                     end
                  end
                  ACT_TICK: begin
                     if (length_ff != '0 && sleep_mode_ff != MODE_OFF) begin
                        state_in = ST_READ;
                        if (passes_ff == '0) begin
                           length_in   = '0;
                           pend_off_in = 1'b1;
                        end else begin
                           pend_off_in = 1'b0;
                           rd_en       = 1'b1;
                           if (next_pos >= length_ff) begin
                              // end of a pass
                              if (passes_ff != COUNT_W'(FOREVER_COUNT)) begin
                                 passes_in = passes_ff - COUNT_W'(1);
                              end
                              pos_in = '0;
                           end else begin
                              pos_in = next_pos[POS_W-1:0];
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            if (rsp_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (pend_off_ff) begin
                  rsp_in = '{red_out: '0, green_out: '0, blue_out: '0, turned_off: 1'b1};
               end else if (sleep_mode_ff == MODE_DIM) begin
                  rsp_in.red_out    = dim_color(rd_data[3*COLOR_W-1:2*COLOR_W]);
                  rsp_in.green_out  = dim_color(rd_data[2*COLOR_W-1:COLOR_W]);
                  rsp_in.blue_out   = dim_color(rd_data[COLOR_W-1:0]);
                  rsp_in.turned_off = 1'b0;
               end else begin
                  rsp_in.red_out    = rd_data[3*COLOR_W-1:2*COLOR_W];
                  rsp_in.green_out  = rd_data[2*COLOR_W-1:COLOR_W];
                  rsp_in.blue_out   = rd_data[COLOR_W-1:0];
                  rsp_in.turned_off = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // a playing tick always goes through the read state
   a_tick_reads: assert property (@(posedge clock) disable iff (reset)
      req_accept && req.action == ACT_TICK && length_ff != '0 && sleep_mode_ff != MODE_OFF
      |=> state_ff == ST_READ)
      else $error("tick did not start a memory read");

   // the read state hands its result over as soon as the output slot is free
   a_read_delivers: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ && rsp_free |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("read result not delivered");

   // the off transaction carries black
   a_off_is_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.turned_off
      |-> rsp_ff.red_out == '0 && rsp_ff.green_out == '0 && rsp_ff.blue_out == '0)
      else $error("off transaction with colour");

   // the off transaction leaves the player idle
   a_off_goes_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ && pend_off_ff |-> length_ff == '0)
      else $error("player still active after off");

endmodule
